// ===== rtl/rcfd_pkg.sv =====
// rcfd_pkg: constants, types and register codes for the rc link frame decoder
// no dependencies; used by rc_link_frame_decoder, rcfd_checker and the bench
package rcfd_pkg;

    localparam int MAX_FRAME_LEN   = 64;
    localparam int PARSED_CHANNELS = 16;
    localparam int RC_PAYLOAD_MIN  = (11 * PARSED_CHANNELS + 7) / 8;
    localparam int BUF_AW          = $clog2(MAX_FRAME_LEN);
    localparam int POS_W           = $clog2(MAX_FRAME_LEN + 1);
    localparam int NUM_W           = 21;
    localparam int DIV_CNT_W       = 5;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RC_FRAME_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX       = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CRC  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

// ===== rtl/rc_link_frame_decoder.sv =====
// rc_link_frame_decoder: byte-serial rc link frame parser with crc-8 check and channel scaling
// depends on rcfd_pkg
//
// usage:
//   input channel (in_valid/in_stall) carries one received byte (rx_byte) and its arrival
//   time in ms (now_ms); a beat is taken when in_valid is high and in_stall is low
//   output channel (out_valid/out_stall) carries one decoded channel per beat: index,
//   scaled value 0..4095, timestamp of the frame's last byte, and a last-channel flag
//   config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the five registers;
//   cfg_ready is always high, index 0 sync, 1 frame type, 2 gap timeout, 3 raw min, 4 raw max
// timing:
//   an ordinary byte is handled in idle; a type or payload byte also runs the bit-serial crc
//   (one bit per cycle in a shared shift/xor unit)
//   a good rc frame then yields its channels one by one, each through 4 buffer reads,
//   one multiply, 21 steps of the shared restoring divider, a finish step and an output step;
//   when raw min equals raw max the divider and finish step are skipped
//   in_stall stays high for the whole frame decode
// reset clears framing state and loads register defaults; the frame buffer is not cleared
// a stalled output beat holds its payload, and decoding of the next channel waits for it
module rc_link_frame_decoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    input  logic [31:0]                        now_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [3:0]                         channel_index,
    output logic [11:0]                        channel_value,
    output logic [31:0]                        frame_time,
    output logic                               last_channel,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);

    // configuration
    logic [7:0]  sync_reg;
    logic [7:0]  type_cfg_reg;
    logic [15:0] gap_reg;
    logic [10:0] min_reg;
    logic [10:0] max_reg;

    // framing
    rcfd_pkg::state_t state_reg, state_next;
    logic [rcfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] last_time_reg;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  ftype_reg, ftype_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [31:0] ftime_reg, ftime_next;

    // frame buffer
    logic [7:0] mem [rcfd_pkg::MAX_FRAME_LEN];
    logic [7:0] rd_data_reg;
    logic [rcfd_pkg::BUF_AW-1:0] rd_addr;
    logic       wr_en;

    // channel decode
    logic [3:0]  k_reg, k_next;
    logic [1:0]  j_reg, j_next;
    logic [23:0] acc_reg, acc_next;
    logic        num_neg_reg, num_neg_next;
    logic        den_neg_reg, den_neg_next;
    logic [rcfd_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [10:0] rem_reg, rem_next;
    logic [10:0] den_reg, den_next;
    logic [rcfd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [11:0] value_reg, value_next;

    logic        in_beat;
    logic        gap;
    logic [rcfd_pkg::POS_W-1:0] pos_eff;
    logic [rcfd_pkg::POS_W:0]   pos_inc;
    logic        len_bad;
    logic [7:0]  bitpos;
    logic [8:0]  byte_idx;
    logic [8:0]  prev_idx;
    logic        prev_ok;
    logic [10:0] raw;
    logic signed [11:0] diff;
    logic signed [22:0] prod;
    logic signed [11:0] den_s;
    logic [11:0] trial;
    logic signed [22:0] q_s;
    logic signed [23:0] v_s;

    assign in_stall  = (state_reg != rcfd_pkg::S_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == rcfd_pkg::S_OUT);
    assign channel_index = k_reg;
    assign channel_value = value_reg;
    assign frame_time    = ftime_reg;
    assign last_channel  = (k_reg == 4'(rcfd_pkg::PARSED_CHANNELS - 1));

    assign gap     = ((now_ms - last_time_reg) > {16'd0, gap_reg});
    assign pos_eff = gap ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos_eff} + 1'b1;
    assign len_bad = (rx_byte < 8'd2) ||
                     ({1'b0, rx_byte} > 9'(rcfd_pkg::MAX_FRAME_LEN - 2));

    // bit position of channel k and the buffer byte for read slot j
    assign bitpos   = 8'({4'd0, k_reg} * 8'd11);
    assign byte_idx = {4'd0, bitpos[7:3]} + {7'd0, j_reg};
    assign prev_idx = byte_idx - 9'd1;
    assign prev_ok  = (prev_idx < 9'(rcfd_pkg::RC_PAYLOAD_MIN)) &&
                      ((prev_idx + 9'd3) < 9'(rcfd_pkg::MAX_FRAME_LEN));
    assign rd_addr  = rcfd_pkg::BUF_AW'(byte_idx + 9'd3);
    assign raw      = 11'(acc_reg >> bitpos[2:0]);

    assign diff  = $signed({1'b0, raw}) - $signed({1'b0, min_reg});
    assign prod  = diff * 23'sd1000;
    assign den_s = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign trial = {rem_reg, quo_reg[rcfd_pkg::NUM_W-1]};

    // floor of the signed quotient from magnitudes
    always_comb
    begin
        if (num_neg_reg != den_neg_reg)
        begin
            q_s = -$signed({2'b00, quo_reg}) - ((rem_reg != '0) ? 23'sd1 : 23'sd0);
        end
        else
        begin
            q_s = $signed({2'b00, quo_reg});
        end
        v_s = 24'sd1000 + 24'(q_s);
    end

    assign wr_en = in_beat && (pos_eff >= rcfd_pkg::POS_W'(2)) &&
                   (pos_eff < rcfd_pkg::POS_W'(rcfd_pkg::MAX_FRAME_LEN));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[rcfd_pkg::BUF_AW'(pos_eff)] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= 8'd200;
            type_cfg_reg <= 8'd22;
            gap_reg      <= 16'd20;
            min_reg      <= 11'd172;
            max_reg      <= 11'd1811;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcfd_pkg::REG_SYNC_ADDRESS:  sync_reg     <= cfg_data[7:0];
                rcfd_pkg::REG_RC_FRAME_TYPE: type_cfg_reg <= cfg_data[7:0];
                rcfd_pkg::REG_GAP_TIMEOUT:   gap_reg      <= cfg_data;
                rcfd_pkg::REG_RAW_MIN:       min_reg      <= cfg_data[10:0];
                rcfd_pkg::REG_RAW_MAX:       max_reg      <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        ftype_next   = ftype_reg;
        bit_cnt_next = bit_cnt_reg;
        ftime_next   = ftime_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        acc_next     = acc_reg;
        num_neg_next = num_neg_reg;
        den_neg_next = den_neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        div_cnt_next = div_cnt_reg;
        value_next   = value_reg;

        unique case (state_reg)
            rcfd_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    if (pos_eff == '0)
                    begin
                        pos_next = (rx_byte == sync_reg) ? rcfd_pkg::POS_W'(1) : '0;
                    end
                    else if (pos_eff == rcfd_pkg::POS_W'(1))
                    begin
                        len_next = rx_byte;
                        crc_next = '0;
                        if (len_bad)
                        begin
                            pos_next = (rx_byte == sync_reg) ? rcfd_pkg::POS_W'(1) : '0;
                        end
                        else
                        begin
                            pos_next = rcfd_pkg::POS_W'(2);
                        end
                    end
                    else if (pos_inc >= (rcfd_pkg::POS_W+1)'(rcfd_pkg::MAX_FRAME_LEN))
                    begin
                        // overflow drops the frame
                        pos_next = '0;
                    end
                    else if (pos_inc == ((rcfd_pkg::POS_W+1)'(len_reg) + 2'd2))
                    begin
                        // crc byte closes the frame
                        pos_next = '0;
                        if ((crc_reg == rx_byte) && (ftype_reg == type_cfg_reg) &&
                            ((len_reg - 8'd2) >= 8'(rcfd_pkg::RC_PAYLOAD_MIN)))
                        begin
                            ftime_next = now_ms;
                            k_next     = '0;
                            j_next     = '0;
                            acc_next   = '0;
                            state_next = rcfd_pkg::S_RD;
                        end
                    end
                    else
                    begin
                        pos_next = rcfd_pkg::POS_W'(pos_inc);
                        if (pos_eff == rcfd_pkg::POS_W'(2))
                        begin
                            ftype_next = rx_byte;
                        end
                        crc_next     = crc_reg ^ rx_byte;
                        bit_cnt_next = '0;
                        state_next   = rcfd_pkg::S_CRC;
                    end
                end
            end

            rcfd_pkg::S_CRC:
            begin
                crc_next = crc_reg[7] ? ({crc_reg[6:0], 1'b0} ^ rcfd_pkg::CRC_POLY)
                                      : {crc_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = rcfd_pkg::S_IDLE;
                end
            end

            rcfd_pkg::S_RD:
            begin
                // data for slot j-1 arrives while slot j is addressed
                if (j_reg != 2'd0)
                begin
                    acc_next[8*(j_reg-2'd1) +: 8] = prev_ok ? rd_data_reg : 8'd0;
                end
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd3)
                begin
                    state_next = rcfd_pkg::S_MUL;
                end
            end

            rcfd_pkg::S_MUL:
            begin
                num_neg_next = prod[22];
                quo_next     = prod[22] ? rcfd_pkg::NUM_W'(-prod) : rcfd_pkg::NUM_W'(prod);
                den_neg_next = den_s[11];
                den_next     = den_s[11] ? 11'(-den_s) : den_s[10:0];
                rem_next     = '0;
                div_cnt_next = '0;
                if (den_s == '0)
                begin
                    // equal min and max: quotient saturates by numerator sign
                    if (prod[22])
                    begin
                        value_next = 12'd0;
                    end
                    else if (prod == '0)
                    begin
                        value_next = 12'd1000;
                    end
                    else
                    begin
                        value_next = 12'd4095;
                    end
                    state_next = rcfd_pkg::S_OUT;
                end
                else
                begin
                    state_next = rcfd_pkg::S_DIV;
                end
            end

            rcfd_pkg::S_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 11'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[rcfd_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[10:0];
                    quo_next = {quo_reg[rcfd_pkg::NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == rcfd_pkg::DIV_CNT_W'(rcfd_pkg::NUM_W - 1))
                begin
                    state_next = rcfd_pkg::S_FIN;
                end
            end

            rcfd_pkg::S_FIN:
            begin
                if (v_s < 0)
                begin
                    value_next = 12'd0;
                end
                else if (v_s > 24'sd4095)
                begin
                    value_next = 12'd4095;
                end
                else
                begin
                    value_next = v_s[11:0];
                end
                state_next = rcfd_pkg::S_OUT;
            end

            rcfd_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_channel)
                    begin
                        state_next = rcfd_pkg::S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        j_next     = '0;
                        acc_next   = '0;
                        state_next = rcfd_pkg::S_RD;
                    end
                end
            end

            default:
            begin
                state_next = rcfd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcfd_pkg::S_IDLE;
            pos_reg       <= '0;
            len_reg       <= '0;
            last_time_reg <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            bit_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            bit_cnt_reg <= bit_cnt_next;
            div_cnt_reg <= div_cnt_next;
            if (in_beat)
            begin
                last_time_reg <= now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        ftype_reg   <= ftype_next;
        ftime_reg   <= ftime_next;
        acc_reg     <= acc_next;
        num_neg_reg <= num_neg_next;
        den_neg_reg <= den_neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        value_reg   <= value_next;
    end

endmodule

// ===== rtl/rcfd_checker.sv =====
// rcfd_checker: port-level assertions, bound into every rc_link_frame_decoder instance
// depends on rcfd_pkg
module rcfd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [7:0]                     rx_byte,
    input logic [31:0]                    now_ms,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [3:0]                     channel_index,
    input logic [11:0]                    channel_value,
    input logic [31:0]                    frame_time,
    input logic                           last_channel,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [15:0]                    cfg_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel_value) &&
        $stable(channel_index) && $stable(frame_time))
        else $error("output beat changed under stall");

    // no byte taken while channels are delivered
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during channel output");

    // last flag marks the final channel
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_channel |->
        channel_index == 4'(rcfd_pkg::PARSED_CHANNELS - 1))
        else $error("last flag on wrong channel");

    // next channel needs decode cycles
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("channel beats back to back");

endmodule

bind rc_link_frame_decoder rcfd_checker u_rcfd_checker (.*);

// ===== bench/tb_rc_link_frame_decoder.sv =====
`timescale 1ns / 1ps
// tb_rc_link_frame_decoder: self-checking bench for the rc link frame decoder
// depends on rcfd_pkg and rc_link_frame_decoder; byte beats in, channel beats out

module tb_rc_link_frame_decoder;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } byte_beat_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [11:0] value;
        logic [31:0] stamp;
        logic        last;
    } chan_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] rx_byte;
    logic [31:0] now_ms;
    logic out_valid;
    logic out_stall;
    logic [3:0] channel_index;
    logic [11:0] channel_value;
    logic [31:0] frame_time;
    logic last_channel;
    logic cfg_valid;
    logic cfg_ready;
    logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    rc_link_frame_decoder dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .frame_time(frame_time),
        .last_channel(last_channel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // stimulus and expectation stores
    byte_beat_t pending_bytes[$];
    chan_beat_t expected_channels[$];
    int         fail_count;
    int         idle_cycles;
    bit         hold_receiver;     // request for a long output hold-off
    bit         sender_paused;

    // predictor copy of registers and framing state
    logic [7:0]  p_sync;
    logic [7:0]  p_type;
    logic [15:0] p_timeout;
    logic [10:0] p_min;
    logic [10:0] p_max;
    int          p_pos;
    int          p_len;
    logic [31:0] p_last_time;
    logic [7:0]  p_buf[rcfd_pkg::MAX_FRAME_LEN];

    // stimulus-side time base
    logic [31:0] stim_time;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc_d5_step(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
            c = c[7] ? ((c << 1) ^ rcfd_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [11:0] scale_channel(logic [10:0] raw);
        longint num;
        longint den;
        longint q;
        longint v;
        num = (longint'(raw) - longint'(p_min)) * 1000;
        den = longint'(p_max) - longint'(p_min);
        if (den == 0)
            return (num > 0) ? 12'd4095 : ((num < 0) ? 12'd0 : 12'd1000);
        q = num / den;
        if ((num % den) != 0 && ((num < 0) != (den < 0)))
            q--;
        v = 1000 + q;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // advance the framing predictor by one accepted byte
    task automatic decode_byte(byte_beat_t bb);
        logic [7:0]  crc;
        logic [23:0] acc;
        int          bitpos;
        chan_beat_t  cb;
        if ((bb.now_ms - p_last_time) > {16'd0, p_timeout})
            p_pos = 0;
        p_last_time = bb.now_ms;
        if (p_pos == 0)
        begin
            if (bb.rx_byte == p_sync)
            begin
                p_buf[0] = bb.rx_byte;
                p_pos = 1;
            end
            return;
        end
        if (p_pos == 1)
        begin
            p_buf[1] = bb.rx_byte;
            p_len = bb.rx_byte;
            p_pos = 2;
            if (p_len < 2 || p_len > rcfd_pkg::MAX_FRAME_LEN - 2)
                p_pos = (bb.rx_byte == p_sync) ? 1 : 0;
            return;
        end
        if (p_pos < rcfd_pkg::MAX_FRAME_LEN)
            p_buf[p_pos] = bb.rx_byte;
        p_pos++;
        if (p_pos >= rcfd_pkg::MAX_FRAME_LEN)
        begin
            p_pos = 0;
            return;
        end
        if (p_pos != p_len + 2)
            return;
        p_pos = 0;
        crc = 8'd0;
        for (int i = 0; i < p_len - 1; i++)
            crc = crc_d5_step(crc, p_buf[2 + i]);
        if (crc != p_buf[p_len + 1] || p_buf[2] != p_type ||
            p_len - 2 < rcfd_pkg::RC_PAYLOAD_MIN)
            return;
        for (int k = 0; k < rcfd_pkg::PARSED_CHANNELS; k++)
        begin
            bitpos = 11 * k;
            acc = '0;
            for (int j = 0; j < 3; j++)
                if ((bitpos >> 3) + j < rcfd_pkg::RC_PAYLOAD_MIN)
                    acc |= 24'(p_buf[3 + (bitpos >> 3) + j]) << (8 * j);
            cb.index = k[3:0];
            cb.value = scale_channel(11'(acc >> (bitpos & 7)));
            cb.stamp = bb.now_ms;
            cb.last = (k == rcfd_pkg::PARSED_CHANNELS - 1);
            expected_channels.push_back(cb);
        end
    endtask

    task automatic queue_byte(logic [7:0] b, int advance);
        byte_beat_t bb;
        stim_time = stim_time + 32'(advance);
        bb.rx_byte = b;
        bb.now_ms = stim_time;
        pending_bytes.push_back(bb);
    endtask

    // a full frame: sync, length, type, payload, crc; corrupt flips crc
    task automatic queue_frame(logic [7:0] ftype, int plen, bit corrupt, int raw_mode);
        logic [7:0] crc;
        logic [7:0] pb;
        queue_byte(p_sync, 1);
        queue_byte(8'(plen + 2), $urandom_range(0, 2));
        queue_byte(ftype, $urandom_range(0, 2));
        crc = crc_d5_step(8'd0, ftype);
        for (int i = 0; i < plen; i++)
        begin
            case (raw_mode)
                1: pb = 8'h00;
                2: pb = 8'hFF;
                default: pb = 8'($urandom_range(0, 255));
            endcase
            crc = crc_d5_step(crc, pb);
            queue_byte(pb, $urandom_range(0, 2));
        end
        queue_byte(corrupt ? ~crc : crc, $urandom_range(0, 2));
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_channels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // register write while idle; mirrors the predictor copy
    task automatic write_reg(logic [rcfd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rcfd_pkg::REG_SYNC_ADDRESS:  p_sync = data[7:0];
            rcfd_pkg::REG_RC_FRAME_TYPE: p_type = data[7:0];
            rcfd_pkg::REG_GAP_TIMEOUT:   p_timeout = data;
            rcfd_pkg::REG_RAW_MIN:       p_min = data[10:0];
            rcfd_pkg::REG_RAW_MAX:       p_max = data[10:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed rc frames with some noise and broken ones
    task automatic random_phase(int n_frames);
        int pick;
        for (int f = 0; f < n_frames; f++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN + $urandom_range(0, 3), 1'b0,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            else if (pick == 13)
                queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b1, 0);
            else if (pick == 14)
                queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0, 0);
            else if (pick == 15)
                queue_frame(p_type, $urandom_range(0, rcfd_pkg::RC_PAYLOAD_MIN - 1), 1'b0, 0);
            else if (pick == 16)
            begin
                // frame cut by a long gap, then resent
                queue_byte(p_sync, 1);
                queue_byte(8'(rcfd_pkg::RC_PAYLOAD_MIN + 2), 1);
                queue_byte(p_type, 1);
                stim_time = stim_time + 32'(p_timeout) + 32'($urandom_range(1, 50));
                queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 0);
            end
            else if (pick == 17)
            begin
                // bad length byte, possibly equal to sync
                queue_byte(p_sync, 1);
                queue_byte($urandom_range(0, 1) ? p_sync : 8'($urandom_range(0, 1)), 1);
                queue_byte(8'($urandom_range(0, 255)), 1);
            end
            else
                for (int i = 0; i < $urandom_range(1, 6); i++)
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 40));
        end
    endtask

    // driver: one beat offered at a time, with random gaps
    int send_gap;
    bit in_taken;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
            now_ms <= '0;
            send_gap = 0;
        end
        else if (in_taken || !in_valid)
        begin
            // previous beat taken at the last rising edge, or none offered
            if (in_taken && pending_bytes.size() != 0)
                void'(pending_bytes.pop_front());
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0 && !sender_paused)
            begin
                in_valid <= 1'b1;
                rx_byte <= pending_bytes[0].rx_byte;
                now_ms <= pending_bytes[0].now_ms;
                send_gap = ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) :
                    $urandom_range(0, 3)) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // predictor tap on accepted input beats
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            decode_byte('{rx_byte, now_ms});
    end

    // receiver stall generator; long hold-off counted here
    int hold_count;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_count = 0;
        end
        else if (hold_receiver && hold_count == 0)
        begin
            hold_count = 600;
            out_stall <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count--;
            out_stall <= (hold_count != 0);
        end
        else
            out_stall <= ($urandom_range(0, 5) == 0) ||
                ($urandom_range(0, 199) == 0 && $urandom_range(0, 1) == 0);
    end

    // monitor: compare each channel beat with the oldest expectation
    chan_beat_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_channels.size() == 0)
            begin
                $error("unexpected channel beat index %0d", channel_index);
                fail_count++;
            end
            else
            begin
                want = expected_channels.pop_front();
                if (channel_index !== want.index)
                begin
                    $error("channel_index exp %0d got %0d", want.index, channel_index);
                    fail_count++;
                end
                if (channel_value !== want.value)
                begin
                    $error("channel_value exp %0d got %0d", want.value, channel_value);
                    fail_count++;
                end
                if (frame_time !== want.stamp)
                begin
                    $error("frame_time exp %0d got %0d", want.stamp, frame_time);
                    fail_count++;
                end
                if (last_channel !== want.last)
                begin
                    $error("last_channel exp %0d got %0d", want.last, last_channel);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction and no config write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        hold_receiver = 1'b0;
        sender_paused = 1'b0;
        p_sync = 8'd200;
        p_type = 8'd22;
        p_timeout = 16'd20;
        p_min = 11'd172;
        p_max = 11'd1811;
        p_pos = 0;
        p_len = 0;
        p_last_time = '0;
        stim_time = 32'd5;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, extremes of payload, bad crc, wrong type, short payload
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 1);
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 2);
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b1, 0);
        queue_frame(8'h00, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 0);
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN - 1, 1'b0, 0);
        queue_frame(p_type, 0, 1'b0, 0);
        // length equal to sync resyncs, overlong frame overflows
        queue_byte(p_sync, 1);
        queue_byte(p_sync, 1);
        queue_byte(8'(rcfd_pkg::RC_PAYLOAD_MIN + 2), 1);
        queue_byte(p_type, 1);
        queue_byte(p_sync, 1);
        queue_byte(8'(rcfd_pkg::MAX_FRAME_LEN - 2), 1);
        for (int i = 0; i < rcfd_pkg::MAX_FRAME_LEN - 2; i++)
            queue_byte(8'($urandom_range(0, 255)), 0);
        queue_byte(p_sync, 1);
        queue_byte(8'd1, 1);
        // gap exactly at the timeout keeps framing
        queue_byte(p_sync, 20);
        queue_byte(8'(rcfd_pkg::RC_PAYLOAD_MIN + 2), 20);
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 0);
        // time wraps past zero
        stim_time = 32'hFFFF_FFF0;
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 0);
        wait_drained();

        // pressure: receiver holds off while the sender keeps offering
        queue_frame(p_type, rcfd_pkg::RC_PAYLOAD_MIN, 1'b0, 0);
        random_phase(1);
        hold_receiver = 1'b1;
        repeat (2) @(posedge clk);
        hold_receiver = 1'b0;
        wait_drained();

        // register settings, extremes included
        write_reg(rcfd_pkg::REG_SYNC_ADDRESS, 16'h00FF);
        write_reg(rcfd_pkg::REG_RC_FRAME_TYPE, 16'h0000);
        write_reg(rcfd_pkg::REG_GAP_TIMEOUT, 16'hFFFF);
        write_reg(rcfd_pkg::REG_RAW_MIN, 16'd0);
        write_reg(rcfd_pkg::REG_RAW_MAX, 16'd2047);
        write_reg(3'd7, 16'h1234);
        random_phase(2);
        wait_drained();

        write_reg(rcfd_pkg::REG_SYNC_ADDRESS, 16'h0000);
        write_reg(rcfd_pkg::REG_RC_FRAME_TYPE, 16'h00FF);
        write_reg(rcfd_pkg::REG_GAP_TIMEOUT, 16'd0);
        write_reg(rcfd_pkg::REG_RAW_MIN, 16'd1000);
        write_reg(rcfd_pkg::REG_RAW_MAX, 16'd1000);
        random_phase(1);
        wait_drained();

        // sender pause after everything is out
        sender_paused = 1'b1;
        repeat (5) @(posedge clk);
        sender_paused = 1'b0;

        write_reg(rcfd_pkg::REG_SYNC_ADDRESS, 16'd200);
        write_reg(rcfd_pkg::REG_RC_FRAME_TYPE, 16'd22);
        write_reg(rcfd_pkg::REG_GAP_TIMEOUT, 16'd30);
        write_reg(rcfd_pkg::REG_RAW_MIN, 16'd2047);
        write_reg(rcfd_pkg::REG_RAW_MAX, 16'd1);
        random_phase(1);
        wait_drained();

        write_reg(rcfd_pkg::REG_RAW_MIN, 16'd172);
        write_reg(rcfd_pkg::REG_RAW_MAX, 16'd1811);
        random_phase(1);
        wait_drained();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
